FILE: hw/rtl/mmn_pkg.sv
// Shared types and constants for the motor mix normalizer.
`timescale 1ns / 1ps
package mmn_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int FRAC_BITS  = 14;
  localparam int CMD_W      = 16;
  localparam int COEF_W     = 16;
  localparam int MIX_W      = 3 * COEF_W;
  localparam int PROD_W     = CMD_W + COEF_W;
  localparam int SUM_W      = 19;
  localparam int RANGE_W    = 20;
  localparam int OUT_W      = 20;
  localparam int QUO_W      = 20;
  localparam int COUNT_W    = 3;
  localparam int IDX_W      = 3;
  localparam int LANE_LAT   = 2;
  localparam int MERGE_LAT  = 1;
  localparam int DIV_LAT    = QUO_W + 1;
  localparam int LATENCY    = LANE_LAT + MERGE_LAT + DIV_LAT;

  localparam logic [RANGE_W-1:0] ONE     = RANGE_W'(1 << FRAC_BITS);
  localparam logic [QUO_W-1:0]   POS_LIM = QUO_W'((1 << (OUT_W - 1)) - 1);
  localparam logic [QUO_W-1:0]   NEG_LIM = QUO_W'(1 << (OUT_W - 1));

  localparam logic [IDX_W-1:0] REG_MOTOR_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIX0        = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIX1        = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIX2        = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIX3        = 3'd4;

  typedef struct packed {
    logic signed [CMD_W-1:0] roll;
    logic signed [CMD_W-1:0] pitch;
    logic signed [CMD_W-1:0] yaw;
  } cmd_vec_t;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [RANGE_W-1:0]      range_t;
  typedef logic signed [OUT_W-1:0] out_t;

endpackage

FILE: hw/rtl/motor_mix_normalizer_core.sv
// Top level of the motor mix normalizer: config, lanes, min/max merge, dividers.
//
// channel  | ports                               | handshake
// input    | in_roll_cmd, in_pitch_cmd, in_yaw_cmd | start high, busy low
// result   | out_motor0_out .. out_motor3_out    | out_valid, one cycle
// config   | cfg_we, cfg_index, cfg_wdata        | cfg_we high
//
// One item per cycle while busy is low. Multiply lanes register products
// then the sum, the min/max merge registers the range, and the divider
// takes one quotient bit per stage plus a sign/saturation register. busy
// is high only in reset and the cycle after; reset clears valid and mix
// registers and sets the count to NUM_MOTORS. The receiver cannot stall.
`timescale 1ns / 1ps
module motor_mix_normalizer_core import mmn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CMD_W-1:0] in_roll_cmd,
  input  logic signed [CMD_W-1:0] in_pitch_cmd,
  input  logic signed [CMD_W-1:0] in_yaw_cmd,
  output logic                    out_valid,
  output out_t                    out_motor0_out,
  output out_t                    out_motor1_out,
  output out_t                    out_motor2_out,
  output out_t                    out_motor3_out,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [MIX_W-1:0]        cfg_wdata
);

  logic [COUNT_W-1:0]    count_r;
  logic [MIX_W-1:0]      mix_r [NUM_MOTORS];
  logic                  busy_r;
  logic [LATENCY-1:0]    vld_r;
  logic                  accept;
  logic [COUNT_W-1:0]    n_act;
  logic [NUM_MOTORS-1:0] act_nxt;
  logic [NUM_MOTORS-1:0] act_r [LANE_LAT + MERGE_LAT];
  cmd_vec_t              cmd;
  sum_t                  sum_w [NUM_MOTORS];
  sum_t                  sum_d_r [NUM_MOTORS];
  logic signed [SUM_W:0] mx, mn;
  logic signed [SUM_W+1:0] span;
  range_t                range_r, range_nxt;
  out_t                  res_w [NUM_MOTORS];

  assign accept = start && !busy;
  assign busy   = busy_r || !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_W'(NUM_MOTORS);
      for (int m = 0; m < NUM_MOTORS; m++) begin
        mix_r[m] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOTOR_COUNT: count_r  <= cfg_wdata[COUNT_W-1:0];
        REG_MIX0:        mix_r[0] <= cfg_wdata;
        REG_MIX1:        mix_r[1] <= cfg_wdata;
        REG_MIX2:        mix_r[2] <= cfg_wdata;
        REG_MIX3:        mix_r[3] <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[LATENCY-2:0], accept};
    end
  end

  assign n_act = (count_r > COUNT_W'(NUM_MOTORS)) ? COUNT_W'(NUM_MOTORS) : count_r;

  always_comb begin
    for (int m = 0; m < NUM_MOTORS; m++) begin
      act_nxt[m] = COUNT_W'(m) < n_act;
    end
  end

  always_ff @(posedge clk) begin
    act_r[0] <= act_nxt;
    for (int s = 1; s < LANE_LAT + MERGE_LAT; s++) begin
      act_r[s] <= act_r[s-1];
    end
  end

  assign cmd.roll  = in_roll_cmd;
  assign cmd.pitch = in_pitch_cmd;
  assign cmd.yaw   = in_yaw_cmd;

  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_lane
    mmn_lane u_lane (
      .clk (clk),
      .cmd (cmd),
      .mix (mix_r[m]),
      .sum (sum_w[m])
    );
  end

  always_comb begin
    mx = -(SUM_W+1)'(2 * ONE);
    mn = (SUM_W+1)'(2 * ONE);
    for (int m = 0; m < NUM_MOTORS; m++) begin
      if (act_r[LANE_LAT-1][m]) begin
        if ((SUM_W+1)'(sum_w[m]) > mx) begin
          mx = (SUM_W+1)'(sum_w[m]);
        end
        if ((SUM_W+1)'(sum_w[m]) < mn) begin
          mn = (SUM_W+1)'(sum_w[m]);
        end
      end
    end
    span      = (SUM_W+2)'(mx) - (SUM_W+2)'(mn);
    range_nxt = (span < $signed((SUM_W+2)'(ONE))) ? ONE : RANGE_W'(span);
  end

  always_ff @(posedge clk) begin
    range_r <= range_nxt;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      sum_d_r[m] <= sum_w[m];
    end
  end

  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_div
    mmn_div u_div (
      .clk    (clk),
      .sum    (sum_d_r[m]),
      .range  (range_r),
      .active (act_r[LANE_LAT + MERGE_LAT - 1][m]),
      .result (res_w[m])
    );
  end

  assign out_valid      = vld_r[LATENCY-1];
  assign out_motor0_out = res_w[0];
  assign out_motor1_out = res_w[1];
  assign out_motor2_out = res_w[2];
  assign out_motor3_out = res_w[3];

endmodule

FILE: hw/rtl/mmn_lane.sv
// One mixing lane: three command-coefficient products and their sum.
`timescale 1ns / 1ps
module mmn_lane import mmn_pkg::*; (
  input  logic              clk,
  input  cmd_vec_t          cmd,
  input  logic [MIX_W-1:0]  mix,
  output sum_t              sum
);

  logic signed [COEF_W-1:0] c_roll, c_pitch, c_yaw;
  logic signed [PROD_W-1:0] p_roll_r, p_pitch_r, p_yaw_r;
  logic signed [PROD_W-1:0] s_roll, s_pitch, s_yaw;
  sum_t                     sum_r, sum_nxt;

  assign c_roll  = mix[COEF_W-1:0];
  assign c_pitch = mix[2*COEF_W-1:COEF_W];
  assign c_yaw   = mix[3*COEF_W-1:2*COEF_W];

  assign s_roll  = p_roll_r >>> FRAC_BITS;
  assign s_pitch = p_pitch_r >>> FRAC_BITS;
  assign s_yaw   = p_yaw_r >>> FRAC_BITS;
  assign sum_nxt = SUM_W'(s_roll) + SUM_W'(s_pitch) + SUM_W'(s_yaw);

  always_ff @(posedge clk) begin
    p_roll_r  <= cmd.roll * c_roll;
    p_pitch_r <= cmd.pitch * c_pitch;
    p_yaw_r   <= cmd.yaw * c_yaw;
    sum_r     <= sum_nxt;
  end

  assign sum = sum_r;

endmodule

FILE: hw/rtl/mmn_div.sv
// Pipelined restoring divider: sum scaled by one over range, saturated.
`timescale 1ns / 1ps
module mmn_div import mmn_pkg::*; (
  input  logic   clk,
  input  sum_t   sum,
  input  range_t range,
  input  logic   active,
  output out_t   result
);

  localparam int REM_W = RANGE_W + QUO_W;

  logic [SUM_W-1:0]   mag;
  logic [REM_W-1:0]   rem_s [QUO_W];
  logic [QUO_W-1:0]   q_s   [QUO_W];
  range_t             den_s [QUO_W];
  logic               neg_s [QUO_W];
  logic               act_s [QUO_W];
  logic [REM_W-1:0]   rem_r [QUO_W];
  logic [QUO_W-1:0]   q_r   [QUO_W];
  range_t             den_r [QUO_W];
  logic               neg_r [QUO_W];
  logic               act_r [QUO_W];
  logic [QUO_W-1:0]   q_fin;
  out_t               res_r, res_nxt;

  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  assign rem_s[0] = REM_W'(mag) << FRAC_BITS;
  assign q_s[0]   = '0;
  assign den_s[0] = range;
  assign neg_s[0] = sum[SUM_W-1];
  assign act_s[0] = active;

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int B = QUO_W - 1 - i;
    logic [REM_W-1:0] trial;
    logic             ge;
    if (i > 0) begin : g_link
      assign rem_s[i] = rem_r[i-1];
      assign q_s[i]   = q_r[i-1];
      assign den_s[i] = den_r[i-1];
      assign neg_s[i] = neg_r[i-1];
      assign act_s[i] = act_r[i-1];
    end
    assign trial = REM_W'(den_s[i]) << B;
    assign ge    = rem_s[i] >= trial;
    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? rem_s[i] - trial : rem_s[i];
      q_r[i]   <= q_s[i] | (QUO_W'(ge) << B);
      den_r[i] <= den_s[i];
      neg_r[i] <= neg_s[i];
      act_r[i] <= act_s[i];
    end
  end

  assign q_fin = q_r[QUO_W-1];

  always_comb begin
    if (!act_r[QUO_W-1]) begin
      res_nxt = '0;
    end else if (neg_r[QUO_W-1]) begin
      res_nxt = (q_fin > NEG_LIM) ? OUT_W'(-NEG_LIM) : OUT_W'(-q_fin);
    end else begin
      res_nxt = (q_fin > POS_LIM) ? OUT_W'(POS_LIM) : OUT_W'(q_fin);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign result = res_r;

endmodule

FILE: hw/rtl/mmn_checker.sv
// Port-level checks for the motor mix normalizer, bound to the top level.
`timescale 1ns / 1ps
module mmn_checker import mmn_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  logic accept;
  assign accept = start && !busy;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("item accepted without a result after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result strobe without a matching item");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy held after reset release");

endmodule

bind motor_mix_normalizer_core mmn_checker u_mmn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
